/* design/cheb_pkg.sv */
package cheb_pkg;

  // Defaults for the top-level parameters.
  localparam int COEF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 30;

  // Fixed widths of the result and of the configuration registers.
  localparam int SUM_W      = 48;
  localparam int EP_W       = 32;
  localparam int BASIS_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_EVAL_POINT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS      = 1'd1;

  // Basis selection codes. The unused code behaves as BASIS_ALL.
  localparam logic [BASIS_W-1:0] BASIS_ALL  = 2'd0;
  localparam logic [BASIS_W-1:0] BASIS_EVEN = 2'd1;
  localparam logic [BASIS_W-1:0] BASIS_ODD  = 2'd2;

endpackage

/* design/chebyshev_series_eval.sv */
// Chebyshev series evaluator. Coefficients stream in on the slave side, one per request,
// and the block accumulates c_i * P_i(x) at the point x held in the eval_point register;
// the request flagged by tlast closes the sum and one result (48-bit saturated sum in
// tdata, sticky clip flag in tuser) leaves on the master side. The polynomial values come
// from the recurrence P(n+1) = 2*s*P(n) - P(n-1), with s = x in the plain basis and
// s = 2x^2-1 in the even and odd parity bases, where the parity bit in tuser of the first
// request of a sum picks the starting order. Every product is floored by arithmetic shift.
// Each coefficient passes from acceptance through the coefficient product, the accumulate
// (while the recurrence product is formed) and the recurrence update, all sequenced through
// one shared multiplier, before the next one is accepted. The first coefficient of a sum
// in a parity basis also passes through a start state that forms 2x^2-1, and a closing
// request waits further while the previous result is still held on the master side. x and the
// basis are sampled at the first coefficient of each sum; write them only while idle.
module chebyshev_series_eval #(
  parameter int COEF_WIDTH = cheb_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = cheb_pkg::FRAC_BITS_DEF,
  localparam int TDATA_W   = ((COEF_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [cheb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cheb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Coefficient stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDATA_W-1:0]              s_axis_tdata,  // [COEF_WIDTH-1:0] coefficient
  input  logic                            s_axis_tuser,  // [0] harmonic_parity
  input  logic                            s_axis_tlast,  // last_coefficient
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cheb_pkg::SUM_W-1:0]      m_axis_tdata,  // [47:0] series_sum
  output logic                            m_axis_tuser   // [0] saturated
);
  import cheb_pkg::*;

  localparam int POLY_W = FRAC_BITS + 2;
  localparam int MUL_W  = (COEF_WIDTH > POLY_W) ? COEF_WIDTH : POLY_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int EXT_W  = (PROD_W > 64) ? PROD_W : 64;
  localparam int RES_W  = 64;
  localparam int WIDE_W = RES_W + 1;

  localparam logic signed [EXT_W-1:0]  BIG_P = EXT_W'(64'sh4000_0000_0000_0000);
  localparam logic signed [EXT_W-1:0]  BIG_N = -BIG_P;
  localparam logic signed [WIDE_W-1:0] ONE_W = WIDE_W'(65'sd1 <<< FRAC_BITS);
  localparam logic signed [POLY_W-1:0] ONE_P = POLY_W'(ONE_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_TERM,
    ST_MACC,
    ST_REC,
    ST_OUT
  } state_e;

  state_e                     state_q, state_d;
  logic signed [EP_W-1:0]     ep_q, ep_d;
  logic [BASIS_W-1:0]         basis_q, basis_d;
  logic signed [COEF_WIDTH-1:0] coef_q, coef_d;
  logic                       last_q, last_d;
  logic                       par_q, par_d;
  logic                       start_q, start_d;
  logic signed [RES_W-1:0]    mul_q;
  logic signed [POLY_W-1:0]   step_q, step_d;
  logic signed [POLY_W-1:0]   cur_q, cur_d;
  logic signed [POLY_W-1:0]   prev_q, prev_d;
  logic signed [SUM_W-1:0]    acc_q, acc_d;
  logic                       clip_q, clip_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0]    out_sum_q, out_sum_d;
  logic                       out_sat_q, out_sat_d;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic                       mul_full_shift;
  logic signed [PROD_W-1:0]   prod;
  logic signed [EXT_W-1:0]    prod_ext, shifted;
  logic signed [RES_W-1:0]    mul_res;

  logic signed [POLY_W-1:0]   x_pol, y_pol, rec_pol;
  logic signed [WIDE_W-1:0]   acc_sum;
  logic signed [SUM_W-1:0]    acc_sat;
  logic                       acc_clip;
  logic                       in_acc, out_free;

  // Clamps a wide signed value into the polynomial width.
  function automatic logic signed [POLY_W-1:0] sat_poly(input logic signed [WIDE_W-1:0] v);
    logic signed [POLY_W-1:0] r;
    if ((v[WIDE_W-1:POLY_W-1] == '0) || (v[WIDE_W-1:POLY_W-1] == '1)) begin
      r = v[POLY_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(POLY_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POLY_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Shared multiplier: floored product with its magnitude clamped to 2^62.
  always_comb begin
    case (state_q)
      ST_IDLE: begin
        mul_a          = MUL_W'(x_pol);
        mul_b          = MUL_W'(x_pol);
        mul_full_shift = 1'b0;
      end
      ST_TERM: begin
        mul_a          = MUL_W'(coef_q);
        mul_b          = MUL_W'(cur_q);
        mul_full_shift = 1'b1;
      end
      default: begin
        mul_a          = MUL_W'(step_q);
        mul_b          = MUL_W'(cur_q);
        mul_full_shift = 1'b0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = EXT_W'(prod);
  assign shifted  = mul_full_shift ? (prod_ext >>> FRAC_BITS) : (prod_ext >>> (FRAC_BITS - 1));

  always_comb begin
    if (shifted > BIG_P) begin
      mul_res = RES_W'(BIG_P);
    end else if (shifted < BIG_N) begin
      mul_res = RES_W'(BIG_N);
    end else begin
      mul_res = shifted[RES_W-1:0];
    end
  end

  assign x_pol   = sat_poly(WIDE_W'(ep_q));
  assign y_pol   = sat_poly(WIDE_W'(mul_q) - ONE_W);
  assign rec_pol = sat_poly(WIDE_W'(mul_q) - WIDE_W'(prev_q));

  assign acc_sum  = WIDE_W'(acc_q) + WIDE_W'(mul_q);
  assign acc_clip = !((acc_sum[WIDE_W-1:SUM_W-1] == '0) || (acc_sum[WIDE_W-1:SUM_W-1] == '1));
  always_comb begin
    if (!acc_clip) begin
      acc_sat = acc_sum[SUM_W-1:0];
    end else if (acc_sum[WIDE_W-1]) begin
      acc_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_d     = state_q;
    ep_d        = ep_q;
    basis_d     = basis_q;
    coef_d      = coef_q;
    last_d      = last_q;
    par_d       = par_q;
    start_d     = start_q;
    step_d      = step_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    acc_d       = acc_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_sum_d   = out_sum_q;
    out_sat_d   = out_sat_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EVAL_POINT: ep_d    = cfg_wdata_i[EP_W-1:0];
        REG_BASIS:      basis_d = cfg_wdata_i[BASIS_W-1:0];
        default:        ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          coef_d  = s_axis_tdata[COEF_WIDTH-1:0];
          last_d  = s_axis_tlast;
          state_d = ST_TERM;
          if (start_q) begin
            start_d = 1'b0;
            acc_d   = '0;
            clip_d  = 1'b0;
            if ((basis_q == BASIS_EVEN) || (basis_q == BASIS_ODD)) begin
              // The square of x is captured in this cycle for 2x^2-1.
              par_d   = (basis_q == BASIS_EVEN) ? s_axis_tuser : !s_axis_tuser;
              state_d = ST_START;
            end else begin
              step_d = x_pol;
              cur_d  = ONE_P;
              prev_d = x_pol;
            end
          end
        end
      end
      ST_START: begin
        // Odd start: T1 = x with prior T(-1) = T1; even start: T0 = 1 with prior T2.
        step_d  = y_pol;
        cur_d   = par_q ? x_pol : ONE_P;
        prev_d  = par_q ? x_pol : y_pol;
        state_d = ST_TERM;
      end
      ST_TERM: begin
        state_d = ST_MACC;
      end
      ST_MACC: begin
        acc_d   = acc_sat;
        clip_d  = clip_q || acc_clip;
        state_d = ST_REC;
      end
      ST_REC: begin
        prev_d = cur_q;
        cur_d  = rec_pol;
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          out_sat_d   = clip_q;
          start_d     = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          out_sat_d   = clip_q;
          start_d     = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ep_q        <= '0;
      basis_q     <= BASIS_ALL;
      coef_q      <= '0;
      last_q      <= 1'b0;
      par_q       <= 1'b0;
      start_q     <= 1'b1;
      mul_q       <= '0;
      step_q      <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_sum_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ep_q        <= ep_d;
      basis_q     <= basis_d;
      coef_q      <= coef_d;
      last_q      <= last_d;
      par_q       <= par_d;
      start_q     <= start_d;
      mul_q       <= mul_res;
      step_q      <= step_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      acc_q       <= acc_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
      out_sum_q   <= out_sum_d;
      out_sat_q   <= out_sat_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sum_q;
  assign m_axis_tuser  = out_sat_q;

endmodule

/* design/cheb_checker.sv */
module cheb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       s_axis_tlast,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [cheb_pkg::SUM_W-1:0] m_axis_tdata,
  input logic                       m_axis_tuser
);
  import cheb_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Each coefficient keeps the block busy after acceptance, through its product, accumulate and update steps.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("coefficient request accepted too early");

  // A coefficient that does not close the sum cannot produce a result.
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tlast |=> !$rose(m_axis_tvalid) ##1 !$rose(m_axis_tvalid))
    else $error("result appeared without a closing coefficient");

  // A new result is only produced at the end of a busy period.
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind chebyshev_series_eval cheb_checker u_cheb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
